/* hw/rtl/pbps_pkg.sv */
// pbps_pkg: shared widths, command codes and helpers for the probe box priority select
// used by the channel interfaces and the top level
package pbps_pkg;

  localparam int COORD_W            = 20;
  localparam int BOX_W              = 3 * COORD_W;
  localparam int BLEND_W            = 19;
  localparam int PRIO_W             = 8;
  localparam int INTEN_W            = 16;
  localparam int FLAG_W             = 2;
  localparam int QUOT_W             = 16;
  localparam int WEIGHT_W           = QUOT_W + 1;
  localparam int PROD_W             = INTEN_W + WEIGHT_W;
  localparam int IDX_W              = 8;
  localparam int DEFAULT_MAX_PROBES = 256;

  // flag bit positions
  localparam int FLAG_ACTIVE = 0;
  localparam int FLAG_BAKED  = 1;

  // weight of 1.0 in Q1.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << QUOT_W;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_PROBE  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // signed add saturated to the coordinate range
  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

/* hw/rtl/pbps_if.sv */
// pbps_in_if / pbps_out_if: valid-ready channels for probe items and results
// depends on pbps_pkg for field widths
interface pbps_in_if import pbps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [BOX_W-1:0]          box_min_offsets;
  logic [BOX_W-1:0]          box_max_offsets;
  logic [BLEND_W-1:0]        blend_distance;
  logic [PRIO_W-1:0]         priority_req;
  logic [INTEN_W-1:0]        intensity;
  logic [FLAG_W-1:0]         probe_flags;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, box_min_offsets,
                  box_max_offsets, blend_distance, priority_req, intensity, probe_flags,
                  input ready);
  modport sink (input valid, cmd, coord_x, coord_y, coord_z, box_min_offsets,
                box_max_offsets, blend_distance, priority_req, intensity, probe_flags,
                output ready);
endinterface

interface pbps_out_if import pbps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [COORD_W-1:0] best_center_x;
  logic signed [COORD_W-1:0] best_center_y;
  logic signed [COORD_W-1:0] best_center_z;
  logic [BOX_W-1:0]          world_box_min;
  logic [BOX_W-1:0]          world_box_max;
  logic [INTEN_W-1:0]        scaled_intensity;
  logic [BLEND_W-1:0]        best_blend;
  logic                      is_baked;
  logic [IDX_W-1:0]          winner_index;

  modport source (output valid, found, best_center_x, best_center_y, best_center_z,
                  world_box_min, world_box_max, scaled_intensity, best_blend, is_baked,
                  winner_index, input ready);
  modport sink (input valid, found, best_center_x, best_center_y, best_center_z,
                world_box_min, world_box_max, scaled_intensity, best_blend, is_baked,
                winner_index, output ready);
endinterface

/* hw/rtl/probe_box_priority_select.sv */
// probe_box_priority_select: picks the best box probe for one query point
// depends on pbps_pkg and the channel interfaces in pbps_if.sv
//
// Usage: in_if carries begin, probe and finish items (valid/ready). A begin item
// latches the query point and clears the selection. Each probe item is tested
// against its saturated world box, weighted by its distance to the nearest face
// and compared against the current best. A finish item emits one result on
// out_if; repeated finishes repeat it. cfg_wr_en/cfg_wr_data write the blend
// threshold and may only be used while the block is idle.
// Sequence: begin, finish, unknown and skipped probes are handled in S_IDLE. An
// active probe passes S_BOX and S_DIST and goes back to idle on a miss; a hit runs
// S_MIN, the radix-2 divider in S_DIV (16 quotient steps) unless its weight is 1.0, then S_MUL and S_UPD. The
// result of a finish is valid in the cycle after its acceptance.
// in_if.ready is low while a probe is in work and while a result waits on a
// stalled receiver; the output register holds the result until taken.
// Reset clears the query point, the selection, the probe count and the threshold.
module probe_box_priority_select import pbps_pkg::*; #(
  parameter int MAX_PROBES = DEFAULT_MAX_PROBES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [BLEND_W-1:0] cfg_wr_data,
  pbps_in_if.sink            in_if,
  pbps_out_if.source         out_if
);

  localparam int CNT_W  = $clog2(MAX_PROBES + 1);
  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOX,
    S_DIST,
    S_MIN,
    S_DIV,
    S_MUL,
    S_UPD
  } state_t;

  state_t               state_r;
  logic [BLEND_W-1:0]   thr_r;
  coord_t               q_r [3];
  logic [CNT_W-1:0]     cnt_r;

  // probe under work
  coord_t               ctr_r [3];
  coord_t               omin_r [3];
  coord_t               omax_r [3];
  coord_t               lo_r [3];
  coord_t               hi_r [3];
  logic [COORD_W-1:0]   dist_r [6];
  logic [BLEND_W-1:0]   blend_r;
  logic [PRIO_W-1:0]    prio_r;
  logic [INTEN_W-1:0]   inten_r;
  logic                 baked_r;
  logic [CNT_W-1:0]     pos_r;

  // divider and multiplier
  logic [BLEND_W-1:0]   rem_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [STEP_W-1:0]    step_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [PROD_W-1:0]    prod_r;

  // current best
  logic                 best_found_r;
  logic [PRIO_W-1:0]    best_prio_r;
  logic [WEIGHT_W-1:0]  best_weight_r;
  coord_t               best_ctr_r [3];
  coord_t               best_lo_r [3];
  coord_t               best_hi_r [3];
  logic [INTEN_W-1:0]   best_scaled_r;
  logic [BLEND_W-1:0]   best_blend_r;
  logic                 best_baked_r;
  logic [IDX_W-1:0]     best_pos_r;

  // result register
  logic                 out_valid_r;
  logic                 out_found_r;
  coord_t               out_ctr_r [3];
  coord_t               out_lo_r [3];
  coord_t               out_hi_r [3];
  logic [INTEN_W-1:0]   out_scaled_r;
  logic [BLEND_W-1:0]   out_blend_r;
  logic                 out_baked_r;
  logic [IDX_W-1:0]     out_pos_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 finish_fire;
  logic                 in_box;
  logic [COORD_W-1:0]   dmin;
  logic [COORD_W-1:0]   dmin_a;
  logic [COORD_W-1:0]   dmin_b;
  logic [COORD_W-1:0]   dmin_c;
  logic [BLEND_W:0]     rem_dbl;
  logic                 rem_ge;
  logic [BLEND_W-1:0]   rem_nxt;
  logic [QUOT_W-1:0]    quot_nxt;
  logic                 better;
  logic [CNT_W+IDX_W-1:0] pos_ext;

  // handshake
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_r && out_if.ready;
  assign finish_fire = in_fire && (cmd_t'(in_if.cmd) == CMD_FINISH);

  // box containment against the query point
  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (q_r[i] < lo_r[i] || q_r[i] > hi_r[i]) begin
        in_box = 1'b0;
      end
    end
  end

  // smallest face distance, small compare tree
  always_comb begin
    dmin_a = (dist_r[0] < dist_r[1]) ? dist_r[0] : dist_r[1];
    dmin_b = (dist_r[2] < dist_r[3]) ? dist_r[2] : dist_r[3];
    dmin_c = (dist_r[4] < dist_r[5]) ? dist_r[4] : dist_r[5];
    dmin   = (dmin_a < dmin_b) ? dmin_a : dmin_b;
    dmin   = (dmin_c < dmin) ? dmin_c : dmin;
  end

  // one restoring division step
  assign rem_dbl  = {rem_r, 1'b0};
  assign rem_ge   = rem_dbl >= {1'b0, blend_r};
  assign rem_nxt  = rem_ge ? BLEND_W'(rem_dbl - {1'b0, blend_r}) : rem_dbl[BLEND_W-1:0];
  assign quot_nxt = {quot_r[QUOT_W-2:0], rem_ge};

  // priority first, then strictly larger weight
  assign better = !best_found_r || (prio_r > best_prio_r) ||
                  ((prio_r == best_prio_r) && (weight_r > best_weight_r));

  assign pos_ext = {{IDX_W{1'b0}}, pos_r};

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= '0;
      cnt_r        <= '0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      // result valid set by a finish, cleared when taken
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (cmd_t'(in_if.cmd))
              CMD_BEGIN: begin
                q_r[0]       <= in_if.coord_x;
                q_r[1]       <= in_if.coord_y;
                q_r[2]       <= in_if.coord_z;
                cnt_r        <= '0;
                best_found_r <= 1'b0;
              end
              CMD_PROBE: begin
                if (cnt_r < CNT_W'(MAX_PROBES)) begin
                  cnt_r    <= cnt_r + 1'b1;
                  pos_r    <= cnt_r;
                  ctr_r[0] <= in_if.coord_x;
                  ctr_r[1] <= in_if.coord_y;
                  ctr_r[2] <= in_if.coord_z;
                  for (int i = 0; i < 3; i++) begin
                    omin_r[i] <= in_if.box_min_offsets[COORD_W*i +: COORD_W];
                    omax_r[i] <= in_if.box_max_offsets[COORD_W*i +: COORD_W];
                  end
                  blend_r <= in_if.blend_distance;
                  prio_r  <= in_if.priority_req;
                  inten_r <= in_if.intensity;
                  baked_r <= in_if.probe_flags[FLAG_BAKED];
                  if (in_if.probe_flags[FLAG_ACTIVE]) begin
                    state_r <= S_BOX;
                  end
                end
              end
              CMD_FINISH: begin
                out_found_r  <= best_found_r;
                out_scaled_r <= best_found_r ? best_scaled_r : '0;
                out_blend_r  <= best_found_r ? best_blend_r : '0;
                out_baked_r  <= best_found_r && best_baked_r;
                out_pos_r    <= best_found_r ? best_pos_r : '0;
                for (int i = 0; i < 3; i++) begin
                  out_ctr_r[i] <= best_found_r ? best_ctr_r[i] : '0;
                  out_lo_r[i]  <= best_found_r ? best_lo_r[i] : '0;
                  out_hi_r[i]  <= best_found_r ? best_hi_r[i] : '0;
                end
              end
              default: ;
            endcase
          end
        end
        // world box, saturated per axis
        S_BOX: begin
          for (int i = 0; i < 3; i++) begin
            lo_r[i] <= sat_add(ctr_r[i], omin_r[i]);
            hi_r[i] <= sat_add(ctr_r[i], omax_r[i]);
          end
          state_r <= S_DIST;
        end
        // containment and face distances
        S_DIST: begin
          for (int i = 0; i < 3; i++) begin
            dist_r[2*i]   <= COORD_W'(q_r[i] - lo_r[i]);
            dist_r[2*i+1] <= COORD_W'(hi_r[i] - q_r[i]);
          end
          state_r <= in_box ? S_MIN : S_IDLE;
        end
        // pick weight path
        S_MIN: begin
          if (blend_r > thr_r && dmin < {1'b0, blend_r}) begin
            rem_r   <= dmin[BLEND_W-1:0];
            quot_r  <= '0;
            step_r  <= STEP_W'(QUOT_W - 1);
            state_r <= S_DIV;
          end else begin
            weight_r <= WEIGHT_ONE;
            state_r  <= S_MUL;
          end
        end
        // radix-2 divider, one quotient bit per cycle
        S_DIV: begin
          rem_r  <= rem_nxt;
          quot_r <= quot_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            weight_r <= {1'b0, quot_nxt};
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(inten_r) * PROD_W'(weight_r);
          state_r <= S_UPD;
        end
        // selection update
        S_UPD: begin
          if (better) begin
            best_found_r  <= 1'b1;
            best_prio_r   <= prio_r;
            best_weight_r <= weight_r;
            best_scaled_r <= prod_r[QUOT_W +: INTEN_W];
            best_blend_r  <= blend_r;
            best_baked_r  <= baked_r;
            best_pos_r    <= pos_ext[IDX_W-1:0];
            for (int i = 0; i < 3; i++) begin
              best_ctr_r[i] <= ctr_r[i];
              best_lo_r[i]  <= lo_r[i];
              best_hi_r[i]  <= hi_r[i];
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_if.valid            = out_valid_r;
  assign out_if.found            = out_found_r;
  assign out_if.best_center_x    = out_ctr_r[0];
  assign out_if.best_center_y    = out_ctr_r[1];
  assign out_if.best_center_z    = out_ctr_r[2];
  assign out_if.world_box_min    = {out_lo_r[2], out_lo_r[1], out_lo_r[0]};
  assign out_if.world_box_max    = {out_hi_r[2], out_hi_r[1], out_hi_r[0]};
  assign out_if.scaled_intensity = out_scaled_r;
  assign out_if.best_blend       = out_blend_r;
  assign out_if.is_baked         = out_baked_r;
  assign out_if.winner_index     = out_pos_r;

  // checks
  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_if.cmd == CMD_FINISH) |=> out_valid_r)
    else $error("finish item produced no result");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> (out_scaled_r == '0) && (out_blend_r == '0) &&
      (out_pos_r == '0) && !out_baked_r)
    else $error("empty result carries nonzero fields");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < blend_r))
    else $error("divider remainder out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PROBES))
    else $error("probe count beyond limit");

endmodule

/* verif/probe_box_priority_select_tb.sv */
// probe_box_priority_select_tb: self-checking bench that drives begin, probe and finish items
// and checks every winner against a predictor of the probe selection
// depends on pbps_pkg, the pbps_in_if/pbps_out_if channels and probe_box_priority_select
module probe_box_priority_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbps_pkg::*;

  localparam int PROBE_LIMIT  = DEFAULT_MAX_PROBES;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_ITEMS = 1600;
  localparam int NUM_PHASES   = 6;
  localparam int COORD_HI     = 524287;
  localparam int COORD_LO     = -524288;

  typedef struct {
    cmd_t                cmd;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic [BOX_W-1:0]    lo_off;
    logic [BOX_W-1:0]    hi_off;
    logic [BLEND_W-1:0]  blend;
    logic [PRIO_W-1:0]   prio;
    logic [INTEN_W-1:0]  inten;
    logic [FLAG_W-1:0]   flags;
  } probe_item_t;

  typedef struct {
    logic                found;
    coord_t              cx;
    coord_t              cy;
    coord_t              cz;
    logic [BOX_W-1:0]    box_lo;
    logic [BOX_W-1:0]    box_hi;
    logic [INTEN_W-1:0]  scaled;
    logic [BLEND_W-1:0]  blend;
    logic                baked;
    logic [IDX_W-1:0]    index;
  } winner_t;

  // tracks the query point and the current best probe, queues winners per finish
  class winner_tracker;
    logic [BLEND_W-1:0] threshold;
    coord_t             query[3];
    int                 best_rank;
    int                 best_weight;
    winner_t            best;
    int                 probe_count;
    winner_t            pending_winners[$];
    int                 errors;

    function new();
      threshold = '0;
      errors = 0;
      probe_count = 0;
      query = '{default: '0};
      clear_best();
    endfunction

    static function int clamp_coord(int v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
    endfunction

    function void clear_best();
      best_rank = -1;
      best_weight = 0;
      best = '{default: '0};
    endfunction

    // world box test, face distance weight and priority compare for one probe
    function void take_probe(probe_item_t it);
      coord_t ctr[3];
      int     lo[3];
      int     hi[3];
      int     dmin;
      int     weight;
      int     pos;
      ctr[0] = it.x;
      ctr[1] = it.y;
      ctr[2] = it.z;
      if (probe_count >= PROBE_LIMIT) return;
      pos = probe_count;
      probe_count++;
      if (!it.flags[FLAG_ACTIVE]) return;
      dmin = 32'h7fff_ffff;
      for (int i = 0; i < 3; i++) begin
        coord_t off_lo;
        coord_t off_hi;
        int     q;
        off_lo = it.lo_off[COORD_W*i +: COORD_W];
        off_hi = it.hi_off[COORD_W*i +: COORD_W];
        q = int'(query[i]);
        lo[i] = clamp_coord(int'(ctr[i]) + int'(off_lo));
        hi[i] = clamp_coord(int'(ctr[i]) + int'(off_hi));
        if (q < lo[i] || q > hi[i]) return;
        if (q - lo[i] < dmin) dmin = q - lo[i];
        if (hi[i] - q < dmin) dmin = hi[i] - q;
      end

      // edge weighting only when the blend distance is above the threshold
      if (it.blend > threshold && dmin < int'(it.blend))
        weight = int'((longint'(dmin) << QUOT_W) / longint'(it.blend));
      else
        weight = 1 << QUOT_W;

      if (int'(it.prio) > best_rank ||
          (int'(it.prio) == best_rank && weight > best_weight)) begin
        best_rank = int'(it.prio);
        best_weight = weight;
        best.cx = ctr[0];
        best.cy = ctr[1];
        best.cz = ctr[2];
        best.box_lo = {lo[2][COORD_W-1:0], lo[1][COORD_W-1:0], lo[0][COORD_W-1:0]};
        best.box_hi = {hi[2][COORD_W-1:0], hi[1][COORD_W-1:0], hi[0][COORD_W-1:0]};
        best.scaled = INTEN_W'((longint'(it.inten) * longint'(weight)) >> QUOT_W);
        best.blend = it.blend;
        best.baked = it.flags[FLAG_BAKED];
        best.index = pos[IDX_W-1:0];
      end
    endfunction

    function void note_item(probe_item_t it);
      winner_t r;
      case (it.cmd)
        CMD_BEGIN: begin
          query = '{it.x, it.y, it.z};
          probe_count = 0;
          clear_best();
        end
        CMD_PROBE: take_probe(it);
        CMD_FINISH: begin
          r = '{default: '0};
          if (best_rank >= 0) begin
            r = best;
            r.found = 1'b1;
          end
          pending_winners = {pending_winners, r};
        end
        default: ;
      endcase
    endfunction

    function void check_field(string field, logic [BOX_W-1:0] want, logic [BOX_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(winner_t got);
      winner_t want;
      if (pending_winners.size() == 0) begin
        $display("%0t: result with no finish pending, expected none, actual found=%0b",
                 $time, got.found);
        errors++;
        return;
      end
      want = pending_winners.pop_front();
      check_field("found", want.found, got.found);
      check_field("best_center_x", want.cx, got.cx);
      check_field("best_center_y", want.cy, got.cy);
      check_field("best_center_z", want.cz, got.cz);
      check_field("world_box_min", want.box_lo, got.box_lo);
      check_field("world_box_max", want.box_hi, got.box_hi);
      check_field("scaled_intensity", want.scaled, got.scaled);
      check_field("best_blend", want.blend, got.blend);
      check_field("is_baked", want.baked, got.baked);
      check_field("winner_index", want.index, got.index);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en;
  logic [BLEND_W-1:0] cfg_wr_data;

  pbps_in_if  in_if ();
  pbps_out_if out_if ();

  probe_box_priority_select dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_if.sink),
    .out_if      (out_if.source)
  );

  winner_tracker tracker = new();
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            sent_items = 0;
  int            quiet_cycles = 0;
  coord_t        cur_point[3];

  always #2 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted items feed the predictor, accepted results are checked, watchdog on silence
  always @(posedge clk) begin
    probe_item_t seen;
    winner_t     got;
    bit          took;
    took = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        seen.cmd = cmd_t'(in_if.cmd);
        seen.x = in_if.coord_x;
        seen.y = in_if.coord_y;
        seen.z = in_if.coord_z;
        seen.lo_off = in_if.box_min_offsets;
        seen.hi_off = in_if.box_max_offsets;
        seen.blend = in_if.blend_distance;
        seen.prio = in_if.priority_req;
        seen.inten = in_if.intensity;
        seen.flags = in_if.probe_flags;
        tracker.note_item(seen);
        took = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.found = out_if.found;
        got.cx = out_if.best_center_x;
        got.cy = out_if.best_center_y;
        got.cz = out_if.best_center_z;
        got.box_lo = out_if.world_box_min;
        got.box_hi = out_if.world_box_max;
        got.scaled = out_if.scaled_intensity;
        got.blend = out_if.best_blend;
        got.baked = out_if.is_baked;
        got.index = out_if.winner_index;
        tracker.check_result(got);
        took = 1'b1;
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one item on the input channel, with random idle cycles ahead of it
  task automatic send(probe_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= it.cmd;
    in_if.coord_x <= it.x;
    in_if.coord_y <= it.y;
    in_if.coord_z <= it.z;
    in_if.box_min_offsets <= it.lo_off;
    in_if.box_max_offsets <= it.hi_off;
    in_if.blend_distance <= it.blend;
    in_if.priority_req <= it.prio;
    in_if.intensity <= it.inten;
    in_if.probe_flags <= it.flags;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (it.cmd != CMD_NONE) sent_items++;
  endtask

  // threshold write once all winners are in and any trailing probe has settled
  task automatic set_threshold(logic [BLEND_W-1:0] value);
    in_if.valid <= 1'b0;
    while (tracker.pending_winners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.threshold = value;
  endtask

  function automatic probe_item_t item_of(cmd_t cmd, coord_t x, coord_t y, coord_t z,
                                          logic [BOX_W-1:0] lo_off,
                                          logic [BOX_W-1:0] hi_off,
                                          logic [BLEND_W-1:0] blend,
                                          logic [PRIO_W-1:0] prio,
                                          logic [INTEN_W-1:0] inten,
                                          logic [FLAG_W-1:0] flags);
    probe_item_t it;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.z = z;
    it.lo_off = lo_off;
    it.hi_off = hi_off;
    it.blend = blend;
    it.prio = prio;
    it.inten = inten;
    it.flags = flags;
    return it;
  endfunction

  // every field random, any command
  function automatic probe_item_t noise_item();
    probe_item_t it;
    it.cmd = cmd_t'($urandom_range(3));
    it.x = coord_t'($urandom);
    it.y = coord_t'($urandom);
    it.z = coord_t'($urandom);
    it.lo_off = BOX_W'({$urandom, $urandom});
    it.hi_off = BOX_W'({$urandom, $urandom});
    it.blend = BLEND_W'($urandom);
    it.prio = PRIO_W'($urandom);
    it.inten = INTEN_W'($urandom);
    it.flags = FLAG_W'($urandom);
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: return coord_t'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  // probe whose box mostly holds the current point, sometimes inverted or unrelated
  function automatic probe_item_t make_probe();
    probe_item_t it;
    int          span;
    int          d;
    int          a;
    int          b;
    it = noise_item();
    it.cmd = CMD_PROBE;
    if ($urandom_range(7) == 0) return it;
    span = ($urandom_range(3) == 0) ? 262143 : 2047;
    for (int i = 0; i < 3; i++) begin
      coord_t c;
      d = int'($urandom_range(2 * span)) - span;
      c = coord_t'(winner_tracker::clamp_coord(int'(cur_point[i]) + d));
      d = int'(cur_point[i]) - int'(c);
      a = $urandom_range(span);
      b = $urandom_range(span);
      if ($urandom_range(15) == 0) begin
        a = -a - 1;
        b = -b - 1;
      end
      it.lo_off[COORD_W*i +: COORD_W] = COORD_W'(winner_tracker::clamp_coord(d - a));
      it.hi_off[COORD_W*i +: COORD_W] = COORD_W'(winner_tracker::clamp_coord(d + b));
      case (i)
        0: it.x = c;
        1: it.y = c;
        default: it.z = c;
      endcase
    end
    case ($urandom_range(7))
      0: it.blend = '0;
      1: it.blend = BLEND_W'($urandom);
      default: it.blend = BLEND_W'($urandom_range(span));
    endcase
    it.prio = ($urandom_range(7) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(3));
    it.flags[FLAG_ACTIVE] = ($urandom_range(7) != 0);
    return it;
  endfunction

  // begin, a list of probes with some noise, one or two finishes
  task automatic run_query(int n_probes);
    probe_item_t it;
    it = noise_item();
    it.cmd = CMD_BEGIN;
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    cur_point = '{it.x, it.y, it.z};
    send(it);
    repeat (n_probes) begin
      if ($urandom_range(15) == 0) send(noise_item());
      else send(make_probe());
    end
    it = noise_item();
    it.cmd = CMD_FINISH;
    send(it);
    if ($urandom_range(9) == 0) send(it);
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_NONE;
    in_if.coord_x <= '0;
    in_if.coord_y <= '0;
    in_if.coord_z <= '0;
    in_if.box_min_offsets <= '0;
    in_if.box_max_offsets <= '0;
    in_if.blend_distance <= '0;
    in_if.priority_req <= '0;
    in_if.intensity <= '0;
    in_if.probe_flags <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    send_idle_pct = 20;
    recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    set_threshold('0);
    // probe ahead of any begin uses the reset point
    send(item_of(CMD_PROBE, 0, 0, 0, {3{coord_t'(-256)}}, {3{coord_t'(256)}},
                 128, 5, 16'hffff, 2'b01));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    // unknown command is dropped
    send(item_of(CMD_NONE, COORD_MAX, COORD_MIN, 0, '1, '1, '1, '1, '1, '1));
    // point at the top corner, boxes saturate upward
    send(item_of(CMD_BEGIN, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0, '0, '0, '0));
    send(item_of(CMD_PROBE, COORD_MAX, COORD_MAX, COORD_MAX, {3{COORD_MIN}},
                 {3{COORD_MAX}}, 100, 0, 16'hffff, 2'b11));
    // inverted box
    send(item_of(CMD_PROBE, COORD_MAX, COORD_MAX, COORD_MAX, {3{coord_t'(10)}},
                 {3{coord_t'(-10)}}, 100, 255, 16'hffff, 2'b01));
    // inactive probe
    send(item_of(CMD_PROBE, COORD_MAX, COORD_MAX, COORD_MAX, {3{COORD_MIN}}, '0,
                 100, 255, 16'hffff, 2'b10));
    // same priority, larger weight wins; equal weight afterwards does not
    send(item_of(CMD_PROBE, COORD_MAX, COORD_MAX, COORD_MAX, {3{COORD_MIN}},
                 {3{COORD_MAX}}, 0, 0, 16'h1234, 2'b01));
    send(item_of(CMD_PROBE, coord_t'(524000), COORD_MAX, COORD_MAX, {3{coord_t'(-500)}},
                 {3{COORD_MAX}}, 0, 0, 16'h4321, 2'b11));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    // bottom corner, saturation downward, lower priority loses
    send(item_of(CMD_BEGIN, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0, '0, '0, '0));
    send(item_of(CMD_PROBE, COORD_MIN, COORD_MIN, COORD_MIN, {3{COORD_MIN}},
                 {3{COORD_MAX}}, '1, 255, 16'h8000, 2'b11));
    send(item_of(CMD_PROBE, COORD_MIN, COORD_MIN, COORD_MIN, {3{COORD_MIN}},
                 {3{coord_t'(100)}}, 0, 254, 16'hffff, 2'b01));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    // finish with no probe reports nothing found
    send(item_of(CMD_BEGIN, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));
    // fractional weights, then a higher priority at full weight
    send(item_of(CMD_BEGIN, 1000, -2000, 3000, '0, '0, '0, '0, '0, '0));
    send(item_of(CMD_PROBE, 1000, -2000, 3000, {3{coord_t'(-1000)}},
                 {3{coord_t'(1000)}}, 3000, 7, 16'hffff, 2'b01));
    send(item_of(CMD_PROBE, 1000, -2000, 3000, {3{coord_t'(-2000)}},
                 {3{coord_t'(2000)}}, 3000, 7, 16'hffff, 2'b11));
    send(item_of(CMD_PROBE, 1000, -2000, 3000, {3{coord_t'(-2000)}},
                 {3{coord_t'(2000)}}, 500, 8, 16'h00ff, 2'b01));
    send(item_of(CMD_FINISH, 0, 0, 0, '0, '0, '0, '0, '0, '0));

    // random phases: idling pattern changes every two phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      int target;
      case (p / 2)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: set_threshold('1);
        2: set_threshold('0);
        3: set_threshold(BLEND_W'($urandom_range(4095)));
        4: set_threshold(BLEND_W'(1));
        default: set_threshold(BLEND_W'($urandom));
      endcase
      target = sent_items + RANDOM_ITEMS / NUM_PHASES;
      // one query past the probe limit
      if (p == 2) run_query(PROBE_LIMIT + 6);
      while (sent_items < target) begin
        if ($urandom_range(9) == 0) send(noise_item());
        run_query($urandom_range(6));
      end
    end

    in_if.valid <= 1'b0;
    while (tracker.pending_winners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
